FILE: rtl/core/irpd_pkg.sv
package irpd_pkg;

    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH = 3'd5;

    localparam logic [15:0] HEADER_MIN_RST = 16'd4000;
    localparam logic [15:0] HEADER_MAX_RST = 16'd5000;
    localparam logic [15:0] MARK_MIN_RST = 16'd400;
    localparam logic [15:0] MARK_MAX_RST = 16'd700;
    localparam logic [15:0] SPACE_MAX_RST = 16'd1800;
    localparam logic [15:0] ONE_THRESH_RST = 16'd1000;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [31:0] CMD_LEFT = 32'hE0E068B7;
    localparam logic [31:0] CMD_NLEFT = 32'hE0E066B7;
    localparam logic [31:0] CMD_RIGHT = 32'hE0E068F7;
    localparam logic [31:0] CMD_NRIGHT = 32'hE0E066F7;
    localparam logic [31:0] CMD_UP = 32'hE0E0F01F;
    localparam logic [31:0] CMD_NUP = 32'hE0E0FF1F;
    localparam logic [31:0] CMD_DOWN = 32'hE0E0E62F;
    localparam logic [31:0] CMD_NDOWN = 32'hE0E0E82F;
    localparam logic [31:0] CMD_SAFETY = 32'hE0E080BF;

    typedef struct packed {
        logic        opcode;
        logic [15:0] interval_us;
    } in_t;

    typedef struct packed {
        logic        frame_done;
        logic [31:0] code_word;
        logic        abort;
        logic        up_flag;
        logic        down_flag;
        logic        left_flag;
        logic        right_flag;
    } out_t;

    typedef struct packed {
        logic [15:0] header_min_us;
        logic [15:0] header_max_us;
        logic [15:0] mark_min_us;
        logic [15:0] mark_max_us;
        logic [15:0] space_max_us;
        logic [15:0] one_threshold_us;
    } cfg_t;

endpackage

FILE: rtl/core/ir_remote_pulse_decoder.sv
// Each input transaction goes into the input register, then its result into the result
// register; the result stays there while out_stall is high.
// Throughput: one transaction per cycle when not stalled; each edge event is decoded by
// a single pass of window compares and command match between the two registers.
// Reset (rst_n, async, active low): decoder idle, bit count, frame word and flags zero,
// timing windows at their default values, both pipeline stages empty.
module ir_remote_pulse_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  irpd_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output irpd_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import irpd_pkg::*;

    cfg_t cfg_reg;
    logic s1_valid_reg;
    in_t  s1_data_reg;
    logic advance;
    logic s1_load;

    assign advance  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_min_us    <= HEADER_MIN_RST;
            cfg_reg.header_max_us    <= HEADER_MAX_RST;
            cfg_reg.mark_min_us      <= MARK_MIN_RST;
            cfg_reg.mark_max_us      <= MARK_MAX_RST;
            cfg_reg.space_max_us     <= SPACE_MAX_RST;
            cfg_reg.one_threshold_us <= ONE_THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_MIN: cfg_reg.header_min_us    <= cfg_data;
                CFG_HEADER_MAX: cfg_reg.header_max_us    <= cfg_data;
                CFG_MARK_MIN:   cfg_reg.mark_min_us      <= cfg_data;
                CFG_MARK_MAX:   cfg_reg.mark_max_us      <= cfg_data;
                CFG_SPACE_MAX:  cfg_reg.space_max_us     <= cfg_data;
                CFG_ONE_THRESH: cfg_reg.one_threshold_us <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= in_data;
        end
    end

    irpd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (s1_valid_reg),
        .item       (s1_data_reg),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    a_done_abort_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.frame_done && out_data.abort))
        else $error("frame_done and abort both set");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid)
        else $error("buffered transaction did not reach the result register");

    a_timeout_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && s1_data_reg.opcode == OP_TIMEOUT)
        |=> (!out_data.frame_done && !out_data.abort))
        else $error("timeout produced done or abort");

endmodule

FILE: rtl/core/irpd_core.sv
module irpd_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          item_valid,
    input  irpd_pkg::in_t item,
    input  irpd_pkg::cfg_t cfg,
    output logic          out_valid,
    output irpd_pkg::out_t out_data
);
    import irpd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_BIT_MARK  = 3'd3,
        PH_BIT_SPACE = 3'd4
    } phase_t;

    // flags: bit0 up, bit1 down, bit2 left, bit3 right
    function automatic logic [3:0] apply_cmd(input logic [31:0] w, input logic [3:0] f);
        logic [3:0] r;
        r = f;
        case (w)
            CMD_SAFETY: r = 4'b0000;
            CMD_LEFT:   r = f | 4'b0100;
            CMD_NLEFT:  r = f & 4'b1011;
            CMD_RIGHT:  r = f | 4'b1000;
            CMD_NRIGHT: r = f & 4'b0111;
            CMD_UP:     r = f | 4'b0001;
            CMD_NUP:    r = f & 4'b1110;
            CMD_DOWN:   r = f | 4'b0010;
            CMD_NDOWN:  r = f & 4'b1101;
            default:    r = f;
        endcase
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  flags_reg, flags_next;
    logic        done_next, abort_next;
    logic        valid_reg;
    out_t        res_reg, res_next;
    logic        take;
    logic        in_hdr, in_mark, in_space;

    assign take = item_valid && advance;

    assign in_hdr = (item.interval_us >= cfg.header_min_us)
                 && (item.interval_us <= cfg.header_max_us);
    assign in_mark = (item.interval_us >= cfg.mark_min_us)
                  && (item.interval_us <= cfg.mark_max_us);
    assign in_space = (item.interval_us >= cfg.mark_min_us)
                   && (item.interval_us <= cfg.space_max_us);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        word_next  = word_reg;
        flags_next = flags_reg;
        done_next  = 1'b0;
        abort_next = 1'b0;
        if (item.opcode == OP_TIMEOUT)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR_MARK, PH_HDR_SPACE:
                begin
                    if (in_hdr)
                    begin
                        phase_next = (phase_reg == PH_HDR_MARK) ? PH_HDR_SPACE : PH_BIT_MARK;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        abort_next = 1'b1;
                    end
                end
                PH_BIT_MARK:
                begin
                    if (in_mark)
                    begin
                        phase_next = PH_BIT_SPACE;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        abort_next = 1'b1;
                    end
                end
                PH_BIT_SPACE:
                begin
                    if (!in_space)
                    begin
                        phase_next = PH_IDLE;
                        abort_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BIT_MARK;
                        if (!count_reg[5])
                        begin
                            // MSB first: bit index is 31 - count
                            word_next[~count_reg[4:0]] = (item.interval_us > cfg.one_threshold_us);
                            count_next = count_reg + 6'd1;
                            if (count_reg[4:0] == 5'd31)
                            begin
                                done_next  = 1'b1;
                                flags_next = apply_cmd(word_next, flags_reg);
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_MARK;
                    count_next = 6'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.frame_done = done_next;
        res_next.code_word  = word_next;
        res_next.abort      = abort_next;
        res_next.up_flag    = flags_next[0];
        res_next.down_flag  = flags_next[1];
        res_next.left_flag  = flags_next[2];
        res_next.right_flag = flags_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 6'd0;
            word_reg  <= 32'd0;
            flags_reg <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= item_valid;
            end
            if (take)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                word_reg  <= word_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

FILE: sim/ir_remote_pulse_decoder_tb.sv
module ir_remote_pulse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE
    } decode_phase_t;

    localparam int FLAG_UP = 0;
    localparam int FLAG_DOWN = 1;
    localparam int FLAG_LEFT = 2;
    localparam int FLAG_RIGHT = 3;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_t queued_events[$];
    out_t predicted_results[$];
    logic [31:0] command_codes [0:8];

    // decoder copy, updated on accepted transactions and register writes
    decode_phase_t dec_phase = PH_IDLE;
    int unsigned bits_seen = 0;
    logic [31:0] frame_word = '0;
    logic [3:0] dir_flags = '0;
    cfg_t cfg_model;
    cfg_t cfg_plan;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b1;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned items_queued = 0;

    ir_remote_pulse_decoder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit in_range(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic out_t decode_event(in_t ev);
        out_t r;
        r = '0;
        if (ev.opcode == OP_TIMEOUT)
        begin
            dec_phase = PH_IDLE;
        end
        else
        begin
            case (dec_phase)
                PH_HDR_MARK, PH_HDR_SPACE:
                begin
                    if (in_range(ev.interval_us, cfg_model.header_min_us,
                                 cfg_model.header_max_us))
                        dec_phase = (dec_phase == PH_HDR_MARK) ? PH_HDR_SPACE : PH_BIT_MARK;
                    else
                    begin
                        dec_phase = PH_IDLE;
                        r.abort = 1'b1;
                    end
                end
                PH_BIT_MARK:
                begin
                    if (in_range(ev.interval_us, cfg_model.mark_min_us, cfg_model.mark_max_us))
                        dec_phase = PH_BIT_SPACE;
                    else
                    begin
                        dec_phase = PH_IDLE;
                        r.abort = 1'b1;
                    end
                end
                PH_BIT_SPACE:
                begin
                    if (!in_range(ev.interval_us, cfg_model.mark_min_us,
                                  cfg_model.space_max_us))
                    begin
                        dec_phase = PH_IDLE;
                        r.abort = 1'b1;
                    end
                    else
                    begin
                        // bits past the 32nd are checked but dropped
                        if (bits_seen < 32)
                        begin
                            frame_word[31 - bits_seen] =
                                ev.interval_us > cfg_model.one_threshold_us;
                            bits_seen++;
                            if (bits_seen == 32)
                            begin
                                r.frame_done = 1'b1;
                                case (frame_word)
                                    CMD_SAFETY: dir_flags = '0;
                                    CMD_LEFT: dir_flags[FLAG_LEFT] = 1'b1;
                                    CMD_NLEFT: dir_flags[FLAG_LEFT] = 1'b0;
                                    CMD_RIGHT: dir_flags[FLAG_RIGHT] = 1'b1;
                                    CMD_NRIGHT: dir_flags[FLAG_RIGHT] = 1'b0;
                                    CMD_UP: dir_flags[FLAG_UP] = 1'b1;
                                    CMD_NUP: dir_flags[FLAG_UP] = 1'b0;
                                    CMD_DOWN: dir_flags[FLAG_DOWN] = 1'b1;
                                    CMD_NDOWN: dir_flags[FLAG_DOWN] = 1'b0;
                                    default: ;
                                endcase
                            end
                        end
                        dec_phase = PH_BIT_MARK;
                    end
                end
                default:
                begin
                    dec_phase = PH_HDR_MARK;
                    bits_seen = 0;
                end
            endcase
        end
        r.code_word = frame_word;
        r.up_flag = dir_flags[FLAG_UP];
        r.down_flag = dir_flags[FLAG_DOWN];
        r.left_flag = dir_flags[FLAG_LEFT];
        r.right_flag = dir_flags[FLAG_RIGHT];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch_ports
        out_t want;
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_MIN: cfg_model.header_min_us = cfg_data;
                CFG_HEADER_MAX: cfg_model.header_max_us = cfg_data;
                CFG_MARK_MIN: cfg_model.mark_min_us = cfg_data;
                CFG_MARK_MAX: cfg_model.mark_max_us = cfg_data;
                CFG_SPACE_MAX: cfg_model.space_max_us = cfg_data;
                CFG_ONE_THRESH: cfg_model.one_threshold_us = cfg_data;
                default: ;
            endcase
        end
        if (in_taken)
            predicted_results.push_back(decode_event(in_data));
        if (out_taken)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %0h",
                         $time, out_data);
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("frame_done", want.frame_done, out_data.frame_done);
                check_field("code_word", want.code_word, out_data.code_word);
                check_field("abort", want.abort, out_data.abort);
                check_field("up_flag", want.up_flag, out_data.up_flag);
                check_field("down_flag", want.down_flag, out_data.down_flag);
                check_field("left_flag", want.left_flag, out_data.left_flag);
                check_field("right_flag", want.right_flag, out_data.right_flag);
            end
        end
        if (in_taken || out_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
    begin : drive_events
        logic next_valid;
        in_t next_data;
        next_valid = in_valid;
        next_data = in_data;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                next_valid = 1'b0;
                send_gap--;
            end
            else if (queued_events.size() > 0)
            begin
                next_data = queued_events.pop_front();
                next_valid = 1'b1;
                if ($urandom_range(0, 63) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 15);
            end
            else
                next_valid = 1'b0;
        end
        in_valid <= next_valid;
        in_data <= next_data;
    end

    always @(negedge clk)
    begin : drive_stall
        if (out_taken)
        begin
            if ($urandom_range(0, 63) == 0)
                recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 15);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_event(logic op, logic [15:0] t);
        in_t ev;
        ev.opcode = op;
        ev.interval_us = t;
        queued_events.push_back(ev);
        items_queued++;
    endtask

    // mostly inside the window, often on a bound, rarely just outside or anywhere
    function automatic logic [15:0] pick_in(int unsigned lo, int unsigned hi);
        int unsigned r;
        if (lo > hi)
            return 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 599);
        if (r == 0)
            return 16'(lo - 1);
        if (r == 1)
            return 16'(hi + 1);
        if (r == 2)
            return 16'($urandom_range(0, 65535));
        if (r < 60)
            return 16'(lo);
        if (r < 120)
            return 16'(hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] space_for(bit one);
        int unsigned lo, hi, thr;
        lo = cfg_plan.mark_min_us;
        hi = cfg_plan.space_max_us;
        thr = cfg_plan.one_threshold_us;
        if (one && thr + 1 > lo)
            lo = thr + 1;
        if (!one && thr < hi)
            hi = thr;
        if (lo > hi)
        begin
            lo = cfg_plan.mark_min_us;
            hi = cfg_plan.space_max_us;
        end
        return pick_in(lo, hi);
    endfunction

    task automatic queue_frame();
        logic [31:0] word;
        int unsigned nbits;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8)
            word = command_codes[$urandom_range(0, 8)];
        else if (r == 8)
            word = command_codes[$urandom_range(0, 8)] ^ (32'h1 << $urandom_range(0, 31));
        else
            word = $urandom;
        r = $urandom_range(0, 9);
        nbits = (r == 0) ? $urandom_range(0, 31) : (r == 1) ? 32 + $urandom_range(1, 4) : 32;
        push_event(OP_EDGE, 16'($urandom_range(0, 65535)));
        push_event(OP_EDGE, pick_in(cfg_plan.header_min_us, cfg_plan.header_max_us));
        push_event(OP_EDGE, pick_in(cfg_plan.header_min_us, cfg_plan.header_max_us));
        for (int i = 0; i < nbits; i++)
        begin
            push_event(OP_EDGE, pick_in(cfg_plan.mark_min_us, cfg_plan.mark_max_us));
            push_event(OP_EDGE, space_for(word[31 - (i % 32)]));
        end
        if (nbits != 32 || $urandom_range(0, 9) != 0)
            push_event(OP_TIMEOUT, 16'($urandom_range(0, 65535)));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int p);
        cfg_t c;
        c.header_min_us = HEADER_MIN_RST;
        c.header_max_us = HEADER_MAX_RST;
        c.mark_min_us = MARK_MIN_RST;
        c.mark_max_us = MARK_MAX_RST;
        c.space_max_us = SPACE_MAX_RST;
        c.one_threshold_us = ONE_THRESH_RST;
        case (p)
            1:
            begin
                c.header_min_us = 16'd0;
                c.header_max_us = 16'hFFFF;
                c.mark_min_us = 16'd0;
                c.mark_max_us = 16'hFFFF;
                c.space_max_us = 16'hFFFF;
                c.one_threshold_us = 16'd0;
            end
            2:
            begin
                c.header_min_us = 16'hFFFF;
                c.header_max_us = 16'hFFFF;
                c.mark_min_us = 16'd0;
                c.mark_max_us = 16'd0;
                c.space_max_us = 16'hFFFF;
                c.one_threshold_us = 16'hFFFF;
            end
            3:
            begin
                // inverted windows
                c.header_min_us = 16'd5000;
                c.header_max_us = 16'd4000;
                c.mark_min_us = 16'd900;
                c.mark_max_us = 16'd300;
                c.space_max_us = 16'd200;
            end
            4:
            begin
                c.header_min_us = 16'($urandom_range(1000, 3000));
                c.header_max_us = 16'(c.header_min_us + $urandom_range(0, 3000));
                c.mark_min_us = 16'($urandom_range(100, 600));
                c.mark_max_us = 16'(c.mark_min_us + $urandom_range(0, 600));
                c.space_max_us = 16'(c.mark_max_us + $urandom_range(0, 2000));
                c.one_threshold_us = 16'($urandom_range(c.mark_min_us, c.space_max_us));
            end
            default: ;
        endcase
        write_reg(CFG_HEADER_MIN, c.header_min_us);
        write_reg(CFG_HEADER_MAX, c.header_max_us);
        write_reg(CFG_MARK_MIN, c.mark_min_us);
        write_reg(CFG_MARK_MAX, c.mark_max_us);
        write_reg(CFG_SPACE_MAX, c.space_max_us);
        write_reg(CFG_ONE_THRESH, c.one_threshold_us);
        cfg_plan = c;
    endtask

    task automatic settle();
        while (queued_events.size() > 0 || in_valid || predicted_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : run_test
        int unsigned target;
        command_codes = '{CMD_LEFT, CMD_NLEFT, CMD_RIGHT, CMD_NRIGHT, CMD_UP,
                          CMD_NUP, CMD_DOWN, CMD_NDOWN, CMD_SAFETY};
        cfg_model.header_min_us = HEADER_MIN_RST;
        cfg_model.header_max_us = HEADER_MAX_RST;
        cfg_model.mark_min_us = MARK_MIN_RST;
        cfg_model.mark_max_us = MARK_MAX_RST;
        cfg_model.space_max_us = SPACE_MAX_RST;
        cfg_model.one_threshold_us = ONE_THRESH_RST;
        cfg_plan = cfg_model;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at reset windows
        push_event(OP_TIMEOUT, 16'hFFFF);
        push_event(OP_EDGE, 16'h0000);
        push_event(OP_EDGE, 16'd4000);
        push_event(OP_EDGE, 16'd5000);
        push_event(OP_EDGE, 16'd400);
        push_event(OP_EDGE, 16'd1800);
        push_event(OP_EDGE, 16'd700);
        push_event(OP_EDGE, 16'd400);
        push_event(OP_EDGE, 16'd500);
        push_event(OP_EDGE, 16'd1000);
        push_event(OP_EDGE, 16'd500);
        push_event(OP_EDGE, 16'd1001);
        push_event(OP_EDGE, 16'd399);
        push_event(OP_EDGE, 16'hFFFF);
        push_event(OP_EDGE, 16'd3999);
        push_event(OP_EDGE, 16'h5A5A);
        push_event(OP_EDGE, 16'd5001);
        push_event(OP_EDGE, 16'h0001);
        push_event(OP_EDGE, 16'd4500);
        push_event(OP_EDGE, 16'd4500);
        push_event(OP_EDGE, 16'd701);
        push_event(OP_EDGE, 16'hA5A5);
        push_event(OP_EDGE, 16'd4500);
        push_event(OP_EDGE, 16'd4500);
        push_event(OP_EDGE, 16'd600);
        push_event(OP_EDGE, 16'd1801);
        push_event(OP_EDGE, 16'd0);
        push_event(OP_TIMEOUT, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                configure(p);
            end
            target = items_queued + ((p == 0) ? 350 : (p == 4) ? 450 : (p == 3) ? 125 : 250);
            while (items_queued < target)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(3, 12))
                        push_event($urandom_range(0, 5) == 0 ? OP_TIMEOUT : OP_EDGE,
                                   16'($urandom_range(0, 65535)));
                end
                else
                    queue_frame();
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/irpd_pkg.sv
rtl/core/irpd_core.sv
rtl/core/ir_remote_pulse_decoder.sv
sim/ir_remote_pulse_decoder_tb.sv
